/* design/sslb_pkg.sv */
package sslb_pkg;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic clear;     // empty the store
		logic begin_srch; // capture key, lo = 0, hi = count
		logic step;      // compare read data against key, narrow lo/hi
		logic above;     // step looks for first entry > key (insert position)
		logic shift_rd;  // read address is idx - 1 instead of mid
		logic move;      // write read data to idx, idx--
		logic begin_shift; // idx = count
		logic insert;    // write key at lo, count++
	} sslb_cmd_t;

	typedef struct packed {
		logic srch_done; // lo >= hi
		logic full;      // count == capacity
		logic at_pos;    // idx == lo
		logic found;     // lo < count
	} sslb_stat_t;

endpackage

/* design/sorted_store_lower_bound.sv */
// Query: binary search with one RAM read per step over the n stored values;
// the result strobe (valid) is raised in the EMIT state that ends the search.
// Load: the same search, then shift entries above up one place and write the key.
// Clear, ignored kinds and loads into a full store finish in IDLE, busy stays low.
// One item at a time (busy high meanwhile); results cannot be stalled.
// Async reset empties the store; RAM contents are not cleared.
module sorted_store_lower_bound #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	output logic               valid,
	output logic               found,
	output logic signed [31:0] answer
);
	import sslb_pkg::*;

	sslb_cmd_t  cmd;
	sslb_stat_t stat;

	sslb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.valid (valid)
	);

	sslb_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.value (value),
		.stat  (stat),
		.found (found),
		.answer(answer)
	);

endmodule

/* design/sslb_ram.sv */
module sslb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/sslb_ctrl.sv */
module sslb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         kind,
	input  sslb_pkg::sslb_stat_t stat,
	output sslb_pkg::sslb_cmd_t  cmd,
	output logic               busy,
	output logic               valid
);
	import sslb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SRCH  = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_MOVE  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       is_load_q, is_load_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			is_load_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			is_load_q <= is_load_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		is_load_d = is_load_q;
		cmd       = '0;
		cmd.above = is_load_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_CLEAR: cmd.clear = 1'b1;
						KIND_LOAD: begin
							// load into a full store is dropped
							if (!stat.full) begin
								cmd.begin_srch = 1'b1;
								is_load_d      = 1'b1;
								state_d        = ST_SRCH;
							end
						end
						KIND_QUERY: begin
							cmd.begin_srch = 1'b1;
							is_load_d      = 1'b0;
							state_d        = ST_SRCH;
						end
						default: ;
					endcase
				end
			end
			ST_SRCH: begin
				if (stat.srch_done) begin
					if (is_load_q) begin
						cmd.begin_shift = 1'b1;
						state_d         = ST_SHIFT;
					end else begin
						state_d = ST_EMIT;
					end
				end else begin
					state_d = ST_CMP; // read at mid issued this cycle
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_SRCH;
			end
			ST_SHIFT: begin
				if (stat.at_pos) begin
					cmd.insert = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d      = ST_MOVE;
				end
			end
			ST_MOVE: begin
				cmd.move = 1'b1;
				state_d  = ST_SHIFT;
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign valid = (state_q == ST_EMIT);

endmodule

/* design/sslb_dp.sv */
module sslb_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sslb_pkg::sslb_cmd_t  cmd,
	input  logic signed [31:0]   value,
	output sslb_pkg::sslb_stat_t stat,
	output logic                 found,
	output logic signed [31:0]   answer
);
	import sslb_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	logic [CW-1:0]      count_q, lo_q, hi_q, idx_q, mid;
	logic signed [31:0] key_q, ans_q, rdata;
	logic [AW-1:0]      raddr, waddr;
	logic [31:0]        wdata, rdata_raw;
	logic               we, below;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign raddr = cmd.shift_rd ? AW'(idx_q - CW'(1)) : mid[AW-1:0];
	assign rdata = rdata_raw;

	// insert position is first entry > key, query wants first entry >= key
	assign below = cmd.above ? (rdata <= key_q) : (rdata < key_q);

	assign we    = cmd.move | cmd.insert;
	assign waddr = cmd.insert ? lo_q[AW-1:0] : idx_q[AW-1:0];
	assign wdata = cmd.insert ? key_q : rdata;

	sslb_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_srch) begin
			key_q <= value;
			lo_q  <= '0;
			hi_q  <= count_q;
		end else if (cmd.step) begin
			if (below) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q  <= mid;
				ans_q <= rdata; // entry at final lo when found
			end
		end
		if (cmd.begin_shift) begin
			idx_q <= count_q;
		end else if (cmd.move) begin
			idx_q <= idx_q - CW'(1);
		end
	end

	assign stat.srch_done = (lo_q >= hi_q);
	assign stat.full      = (count_q == CAP);
	assign stat.at_pos    = (idx_q == lo_q);
	assign stat.found     = (lo_q < count_q);

	assign found  = stat.found;
	assign answer = stat.found ? ans_q : 32'sd0;

endmodule
